FILE: design/tra_pkg.sv
`timescale 1ns / 1ps

package tra_pkg;

  localparam int GRID_MAX_DEF = 32;

  localparam int CFG_W   = 6;
  localparam int POS_W   = 5;
  localparam int SIZE_W  = 6;
  localparam int COORD_W = 6;
  localparam int SUM_W   = 8;
  localparam int ACT_W   = 2;
  localparam int STS_W   = 2;
  localparam int DATA_W  = 24;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [CFG_W-1:0] GRID_RST = CFG_W'(32);

  localparam logic [APB_AW-3:0] REG_GRID = '0;

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RESERVE = 2'd1,
    ACT_FREE    = 2'd2,
    ACT_NOP     = 2'd3
  } act_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK      = 2'd0,
    STS_TOO_BIG = 2'd1,
    STS_NO_FIT  = 2'd2,
    STS_BOUNDS  = 2'd3
  } sts_e;

endpackage

FILE: design/tra_bitmap.sv
`timescale 1ns / 1ps

module tra_bitmap #(
  parameter int GRID_MAX = tra_pkg::GRID_MAX_DEF,
  parameter int AW       = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [AW-1:0]       rd_addr_i,
  output logic [GRID_MAX-1:0] rd_data_o,
  input  logic                wr_en_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  logic [GRID_MAX-1:0] wr_data_i
);
  import tra_pkg::*;

  logic [GRID_MAX-1:0] mem_q [GRID_MAX];
  logic [GRID_MAX-1:0] vld_q;
  logic [GRID_MAX-1:0] rdat_q;
  logic                rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdat_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // unwritten columns read as free
  assign rd_data_o = rvld_q ? rdat_q : '0;

endmodule

FILE: design/tile_region_allocator_2d_core.sv
`timescale 1ns / 1ps

// Channel  Dir  Payload                                            Beat when
// s_axis   in   tuser: action; tdata: pos_x, pos_y, width, height  tvalid & tready
// m_axis   out  tuser: status; tdata: found_x, found_y, w, h       tvalid & tready
// apb      in   grid_tiles at byte address 0                       psel & penable & pwrite
//
// One request at a time; s_axis_tready is high only while the sequencer is idle.
// Reserve/free: one bitmap read-modify-write per column.
// Allocate: per candidate column x, the w columns are ORed through the single
// bitmap read port, then the shared window compare steps over the candidate rows;
// a hit then marks the region through the same column walk.
// Reset clears the bitmap through per-column valid bits at once; no clearing pass.
// A finished result waits in the output register while the next request is taken.

module tile_region_allocator_2d_core #(
  parameter int GRID_MAX = tra_pkg::GRID_MAX_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [tra_pkg::DATA_W-1:0]  s_axis_tdata,  // pos_x, pos_y, width, height
  input  logic [tra_pkg::ACT_W-1:0]   s_axis_tuser,  // action
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [tra_pkg::DATA_W-1:0]  m_axis_tdata,  // found_x, found_y, out_width, out_height
  output logic [tra_pkg::STS_W-1:0]   m_axis_tuser,  // status
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tra_pkg::APB_AW-1:0]  paddr,
  input  logic [tra_pkg::APB_DW-1:0]  pwdata,
  output logic [tra_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import tra_pkg::*;

  localparam int AW = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
  localparam int G  = GRID_MAX;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_PREP,
    S_MARK,
    S_DONE
  } state_e;

  state_e              state_q, state_d;
  logic [CFG_W-1:0]    grid_q;
  logic [COORD_W-1:0]  x_q, x_d, y_q, y_d;
  logic [SIZE_W-1:0]   w_q, w_d, h_q, h_d;
  logic [SUM_W-1:0]    n_q, n_d;
  logic [G-1:0]        hmask_q, hmask_d, acc_q, acc_d, mask_q, mask_d;
  logic [SIZE_W-1:0]   cnt_q, cnt_d;
  logic                pend_q, pend_d;
  logic [AW-1:0]       pcol_q, pcol_d;
  logic                used_q, used_d;
  sts_e                st_q, st_d;

  logic                ovld_q;
  sts_e                ost_q;
  logic [POS_W-1:0]    ox_q, oy_q;
  logic [SIZE_W-1:0]   ow_q, oh_q;

  logic [POS_W-1:0]    in_x, in_y;
  logic [SIZE_W-1:0]   in_w, in_h;
  logic [SUM_W-1:0]    grid8, gmax8, n_in;
  logic                s_beat, cfg_wr, out_free;
  logic                rd_en, wr_en;
  logic [AW-1:0]       rd_addr;
  logic [G-1:0]        rd_data, wr_data;
  logic [SUM_W-1:0]    col_sum;
  logic                issuing;

  assign in_x = s_axis_tdata[4:0];
  assign in_y = s_axis_tdata[9:5];
  assign in_w = s_axis_tdata[15:10];
  assign in_h = s_axis_tdata[21:16];

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_beat        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !ovld_q || m_axis_tready;

  assign pready = 1'b1;
  assign prdata = APB_DW'(grid_q);
  assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_GRID);

  assign grid8 = SUM_W'(grid_q);
  assign gmax8 = SUM_W'(GRID_MAX);
  assign n_in  = (grid8 < gmax8) ? grid8 : gmax8;

  // column walk shared by the load and mark passes
  assign issuing = (state_q == S_LOAD || state_q == S_MARK) && (cnt_q != w_q);
  assign col_sum = SUM_W'(x_q) + SUM_W'(cnt_q);
  assign rd_en   = issuing;
  assign rd_addr = col_sum[AW-1:0];
  assign wr_en   = (state_q == S_MARK) && pend_q;
  assign wr_data = used_q ? (rd_data | mask_q) : (rd_data & ~mask_q);

  tra_bitmap #(
    .GRID_MAX (GRID_MAX),
    .AW       (AW)
  ) u_bitmap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (pcol_q),
    .wr_data_i (wr_data)
  );

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    y_d     = y_q;
    w_d     = w_q;
    h_d     = h_q;
    n_d     = n_q;
    hmask_d = hmask_q;
    acc_d   = acc_q;
    mask_d  = mask_q;
    cnt_d   = cnt_q;
    pend_d  = pend_q;
    pcol_d  = pcol_q;
    used_d  = used_q;
    st_d    = st_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_beat) begin
          w_d     = in_w;
          h_d     = in_h;
          n_d     = n_in;
          hmask_d = ~({G{1'b1}} << in_h);
          x_d     = COORD_W'(in_x);
          y_d     = COORD_W'(in_y);
          cnt_d   = '0;
          pend_d  = 1'b0;
          acc_d   = '0;
          used_d  = (act_e'(s_axis_tuser) != ACT_FREE);
          st_d    = STS_BOUNDS;
          unique case (act_e'(s_axis_tuser))
            ACT_ALLOC: begin
              x_d = '0;
              y_d = '0;
              if (in_w == '0 || in_h == '0 || SUM_W'(in_w) > n_in ||
                  SUM_W'(in_h) > n_in) begin
                st_d    = STS_TOO_BIG;
                state_d = S_DONE;
              end else begin
                state_d = S_LOAD;
              end
            end
            ACT_RESERVE, ACT_FREE: begin
              if (in_w != '0 && in_h != '0 &&
                  SUM_W'(in_x) + SUM_W'(in_w) <= n_in &&
                  SUM_W'(in_y) + SUM_W'(in_h) <= n_in) begin
                st_d    = STS_OK;
                state_d = S_PREP;
              end else begin
                state_d = S_DONE;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      S_LOAD: begin
        if (pend_q) begin
          acc_d = acc_q | rd_data;
        end
        if (issuing) begin
          cnt_d  = cnt_q + 1'b1;
          pend_d = 1'b1;
          pcol_d = rd_addr;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            y_d     = '0;
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if ((acc_q & hmask_q) == '0) begin
          state_d = S_PREP;
        end else if (SUM_W'(y_q) + SUM_W'(h_q) + 1'b1 <= n_q) begin
          y_d   = y_q + 1'b1;
          acc_d = acc_q >> 1;
        end else if (SUM_W'(x_q) + SUM_W'(w_q) + 1'b1 <= n_q) begin
          x_d     = x_q + 1'b1;
          cnt_d   = '0;
          acc_d   = '0;
          state_d = S_LOAD;
        end else begin
          x_d     = '0;
          y_d     = '0;
          st_d    = STS_NO_FIT;
          state_d = S_DONE;
        end
      end

      S_PREP: begin
        mask_d  = hmask_q << y_q;
        cnt_d   = '0;
        pend_d  = 1'b0;
        state_d = S_MARK;
      end

      S_MARK: begin
        if (issuing) begin
          cnt_d  = cnt_q + 1'b1;
          pend_d = 1'b1;
          pcol_d = rd_addr;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            st_d    = STS_OK;
            state_d = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      grid_q  <= GRID_RST;
      ovld_q  <= 1'b0;
      pend_q  <= 1'b0;
      cnt_q   <= '0;
      ost_q   <= STS_OK;
      ox_q    <= '0;
      oy_q    <= '0;
      ow_q    <= '0;
      oh_q    <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
      if (cfg_wr) begin
        grid_q <= pwdata[CFG_W-1:0];
      end
      if (state_q == S_DONE && out_free) begin
        ovld_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovld_q <= 1'b0;
      end
      if (state_q == S_DONE && out_free) begin
        ost_q <= st_q;
        ox_q  <= x_q[POS_W-1:0];
        oy_q  <= y_q[POS_W-1:0];
        ow_q  <= w_q;
        oh_q  <= h_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    w_q     <= w_d;
    h_q     <= h_d;
    n_q     <= n_d;
    hmask_q <= hmask_d;
    acc_q   <= acc_d;
    mask_q  <= mask_d;
    pcol_q  <= pcol_d;
    used_q  <= used_d;
    st_q    <= st_d;
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tuser  = ost_q;
  assign m_axis_tdata  = {2'b00, oh_q, ow_q, oy_q, ox_q};

endmodule
